// ===== src/worst_fit_block_allocator_top_assert.svh =====
// ---------------------------------------------------------------------------
// Worst-fit allocator assertion macros
// Shared concurrent checks, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define WFBA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wfba check failed");

// next-cycle implication
`define WFBA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wfba check failed");

`endif

// ===== src/wfba_pkg.sv =====
// ---------------------------------------------------------------------------
// wfba_pkg
// Types and constants shared by the worst-fit allocator and its cells.
// ---------------------------------------------------------------------------
package wfba_pkg;

	localparam int MAX_SEGMENTS    = 64;
	localparam int HEADER_BYTES    = 16;
	localparam int ARENA_MAX_BYTES = 65536;
	localparam int ARENA_RESET     = 4096;

	localparam int ADDR_W = 16;
	localparam int LEN_W  = 17;
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

	localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0] ARENA_MAX = LEN_W'(ARENA_MAX_BYTES);
	localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(ARENA_RESET - HEADER_BYTES);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_NO_FIT    = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef struct packed {
		logic [0:0]        command;
		logic [LEN_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] block_offset;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] payload_offset;
		logic [LEN_W-1:0]  granted_bytes;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
		logic              used;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INIT,
		OP_UPDATE
	} op_code_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_INS,
		SH_REM
	} shift_t;

	typedef struct packed {
		op_code_t          code;
		logic [IDX_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
		logic              used;
		shift_t            shift;
		logic [ADDR_W-1:0] nstart;
		logic [LEN_W-1:0]  nlen;
	} op_t;

	typedef struct packed {
		logic              is_free;
		logic [LEN_W-1:0]  req;
		logic [ADDR_W-1:0] target;
		logic [CNT_W-1:0]  count;
	} scan_ctl_t;

	// record handed from cell to cell during a scan
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] start;
		logic              cur_used;
		logic [LEN_W-1:0]  cur_len;
		logic              need_next;
		logic              nu;
		logic [LEN_W-1:0]  nl;
		logic              pu;
		logic [LEN_W-1:0]  pl;
	} scan_t;

endpackage

// ===== src/wfba_cell.sv =====
// ---------------------------------------------------------------------------
// wfba_cell
// One segment table entry plus one stage of the scan chain.
// ---------------------------------------------------------------------------
module wfba_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wfba_pkg::IDX_W-1:0] cell_idx,
	input  wfba_pkg::op_t             op,
	input  wfba_pkg::scan_ctl_t       ctl,
	input  wfba_pkg::entry_t          ent_left,
	input  wfba_pkg::entry_t          ent_right,
	output wfba_pkg::entry_t          ent,
	input  wfba_pkg::scan_t           rec_in,
	output wfba_pkg::scan_t           rec_out
);
	import wfba_pkg::*;

	entry_t              ent_q;
	scan_t               rec_q;
	scan_t               rec_d;
	logic                active;
	logic                eff_used;
	logic [IDX_W:0]      idx_ext;
	logic [IDX_W:0]      op_idx_ext;
	logic [LEN_W-1:0]    pay_off;

	assign ent        = ent_q;
	assign rec_out    = rec_q;
	assign idx_ext    = {1'b0, cell_idx};
	assign op_idx_ext = {1'b0, op.idx};
	assign active     = CNT_W'(idx_ext) < ctl.count;
	assign eff_used   = active ? ent_q.used : 1'b1;
	assign pay_off    = LEN_W'(ent_q.start) + HDR_LEN;

	always_comb begin
		rec_d          = rec_in;
		rec_d.cur_used = eff_used;
		rec_d.cur_len  = ent_q.len;
		if (rec_in.need_next) begin
			rec_d.nu        = eff_used;
			rec_d.nl        = ent_q.len;
			rec_d.need_next = 1'b0;
		end
		if (!ctl.is_free) begin
			if (active && !ent_q.used && ent_q.len >= ctl.req &&
				(!rec_in.found || ent_q.len > rec_in.len)) begin
				rec_d.found = 1'b1;
				rec_d.idx   = cell_idx;
				rec_d.len   = ent_q.len;
				rec_d.start = ent_q.start;
			end
		end else if (active && ent_q.used && !rec_in.found &&
			pay_off == LEN_W'(ctl.target)) begin
			rec_d.found     = 1'b1;
			rec_d.idx       = cell_idx;
			rec_d.len       = ent_q.len;
			rec_d.start     = ent_q.start;
			rec_d.pu        = rec_in.cur_used;
			rec_d.pl        = rec_in.cur_len;
			rec_d.need_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{start: '0, len: RESET_LEN, used: 1'b0};
		end else begin
			unique case (op.code)
				OP_HOLD: begin
				end
				OP_INIT: begin
					if (cell_idx == '0) begin
						ent_q <= '{start: '0, len: op.len, used: 1'b0};
					end
				end
				OP_UPDATE: begin
					if (cell_idx == op.idx) begin
						ent_q.len  <= op.len;
						ent_q.used <= op.used;
					end else if (op.shift == SH_INS) begin
						if (idx_ext == op_idx_ext + 1'b1) begin
							ent_q <= '{start: op.nstart, len: op.nlen, used: 1'b0};
						end else if (idx_ext > op_idx_ext + 1'b1) begin
							ent_q <= ent_left;
						end
					end else if (op.shift == SH_REM && cell_idx > op.idx) begin
						ent_q <= ent_right;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
	end

endmodule

// ===== src/worst_fit_block_allocator_top.sv =====
// ---------------------------------------------------------------------------
// worst_fit_block_allocator_top
// Worst-fit allocator over a byte arena, kept as a chain of segment cells.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive item and raise start; the transfer happens at a
//   clock edge with start high and busy low. command 0 allocates
//   request_bytes, command 1 frees the block at block_offset.
//   Result channel: result_valid is high for one cycle with result; the
//   receiver cannot stall it and must take it in that cycle.
//   Config channel: cfg_data is the arena size, written when cfg_valid and
//   cfg_ready are both high; cfg_ready is high while no request is in work.
//   A write resets the table to one free segment.
// Timing:
//   Each request runs a scan wave through the 64-cell chain, one cell per
//   cycle, then a table update; a free that merges with its left
//   neighbour adds the S_MERGE_L update state. The next request may be
//   started in the cycle result_valid is shown.
// Reset: arena 4096 bytes, one free segment, no result pending.
// ---------------------------------------------------------------------------
`include "worst_fit_block_allocator_top_assert.svh"

module worst_fit_block_allocator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  wfba_pkg::item_t           item,
	output logic                      result_valid,
	output wfba_pkg::result_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [wfba_pkg::LEN_W-1:0] cfg_data
);
	import wfba_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MERGE_L
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [LEN_W-1:0]    arena_q;
	logic [CNT_W-1:0]    step_q;
	item_t               item_q;
	logic [IDX_W-1:0]    fidx_q;
	logic [LEN_W-1:0]    l1_q;
	logic [LEN_W-1:0]    pl_q;
	logic                result_valid_q;
	result_t             result_q;

	op_t                 op;
	scan_ctl_t           ctl;
	scan_t               rec [MAX_SEGMENTS+1];
	entry_t              ent [MAX_SEGMENTS];
	scan_t               last;
	logic                decide;
	logic [LEN_W-1:0]    cfg_sat;
	logic [LEN_W-1:0]    init_len;
	logic                too_large;
	logic [LEN_W-1:0]    left;
	logic                split;
	logic                full;
	logic                rf;
	logic                lf;
	logic [LEN_W-1:0]    l1;

	assign busy         = state_q != S_IDLE;
	assign cfg_ready    = state_q == S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ctl = '{is_free: item_q.command == CMD_FREE, req: item_q.request_bytes,
		target: item_q.block_offset, count: count_q};

	assign rec[0] = '{found: 1'b0, idx: '0, len: '0, start: '0, cur_used: 1'b1,
		cur_len: '0, need_next: 1'b0, nu: 1'b1, nl: '0, pu: 1'b1, pl: '0};

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		wfba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.op       (op),
			.ctl      (ctl),
			.ent_left (ent[(g == 0) ? 0 : g-1]),
			.ent_right(ent[(g == MAX_SEGMENTS-1) ? g : g+1]),
			.ent      (ent[g]),
			.rec_in   (rec[g]),
			.rec_out  (rec[g+1])
		);
	end

	assign last      = rec[MAX_SEGMENTS];
	assign decide    = state_q == S_SCAN && step_q == CNT_W'(MAX_SEGMENTS);
	assign cfg_sat   = (cfg_data > ARENA_MAX) ? ARENA_MAX : cfg_data;
	assign init_len  = (cfg_sat > HDR_LEN) ? cfg_sat - HDR_LEN : '0;
	assign too_large = item_q.request_bytes > arena_q;
	assign left      = last.len - item_q.request_bytes;
	assign split     = left > HDR_LEN;
	assign full      = split && count_q == CNT_W'(MAX_SEGMENTS);
	assign rf        = !last.nu;
	assign lf        = !last.pu;
	assign l1        = rf ? last.len + HDR_LEN + last.nl : last.len;

	always_comb begin
		op = '{code: OP_HOLD, idx: '0, len: '0, used: 1'b0, shift: SH_NONE,
			nstart: '0, nlen: '0};
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					op.code = OP_INIT;
					op.len  = init_len;
				end
			end
			S_SCAN: begin
				if (decide && last.found) begin
					if (item_q.command == CMD_ALLOC) begin
						if (!too_large && !full) begin
							op.code   = OP_UPDATE;
							op.idx    = last.idx;
							op.used   = 1'b1;
							op.len    = split ? item_q.request_bytes : last.len;
							op.shift  = split ? SH_INS : SH_NONE;
							op.nstart = ADDR_W'(LEN_W'(last.start) + HDR_LEN
								+ item_q.request_bytes);
							op.nlen   = left - HDR_LEN;
						end
					end else begin
						op.code  = OP_UPDATE;
						op.idx   = last.idx;
						op.used  = 1'b0;
						op.len   = l1;
						op.shift = rf ? SH_REM : SH_NONE;
					end
				end
			end
			S_MERGE_L: begin
				op.code  = OP_UPDATE;
				op.idx   = fidx_q - 1'b1;
				op.used  = 1'b0;
				op.len   = pl_q + HDR_LEN + l1_q;
				op.shift = SH_REM;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= CNT_W'(1);
			arena_q        <= LEN_W'(ARENA_RESET);
			step_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			item_q         <= '0;
			fidx_q         <= '0;
			l1_q           <= '0;
			pl_q           <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						arena_q <= cfg_sat;
						count_q <= CNT_W'(1);
					end
					if (start) begin
						item_q  <= item;
						step_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					step_q <= step_q + 1'b1;
					if (decide) begin
						result_q <= '0;
						state_q  <= S_IDLE;
						if (item_q.command == CMD_ALLOC) begin
							result_valid_q <= 1'b1;
							if (too_large) begin
								result_q.status <= ST_TOO_LARGE;
							end else if (!last.found) begin
								result_q.status <= ST_NO_FIT;
							end else if (full) begin
								result_q.status <= ST_FULL;
							end else begin
								result_q.status         <= ST_OK;
								result_q.payload_offset <= last.start + ADDR_W'(HEADER_BYTES);
								result_q.granted_bytes  <=
									split ? item_q.request_bytes : last.len;
								if (split) begin
									count_q <= count_q + 1'b1;
								end
							end
						end else if (!last.found) begin
							result_valid_q  <= 1'b1;
							result_q.status <= ST_BAD_FREE;
						end else begin
							result_q.status <= ST_OK;
							if (rf) begin
								count_q <= count_q - 1'b1;
							end
							if (lf) begin
								fidx_q  <= last.idx;
								l1_q    <= l1;
								pl_q    <= last.pl;
								state_q <= S_MERGE_L;
							end else begin
								result_valid_q <= 1'b1;
							end
						end
					end
				end
				S_MERGE_L: begin
					count_q        <= count_q - 1'b1;
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`WFBA_ASSERT_IMP(a_count_range, 1'b1, count_q != '0 && count_q <= CNT_W'(MAX_SEGMENTS))
	`WFBA_ASSERT_IMP(a_fail_zero, result_valid && result.status != ST_OK,
		result.payload_offset == '0 && result.granted_bytes == '0)
	`WFBA_ASSERT_NXT(a_start_busy, start && !busy, busy)
	`WFBA_ASSERT_NXT(a_cfg_count, cfg_valid && cfg_ready && !start, count_q == CNT_W'(1))

endmodule
